// ----- sv/trc_pkg.sv -----
// trc_pkg: shared types and constants for the thermostat relay controller
// no dependencies; used by trc_core, trc_out_buf and the top level
package trc_pkg;

    localparam int unsigned TEMP_W  = 13;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned PAUSE_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_TDATA_W = 16;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        MODE_STANDBY = 2'd0,
        MODE_HEATING = 2'd1,
        MODE_COOLING = 2'd2
    } t_mode;

    localparam logic [PAUSE_W-1:0] PAUSE_STANDBY = 3'd0;
    localparam logic [PAUSE_W-1:0] PAUSE_HEATER  = 3'd1;
    localparam logic [PAUSE_W-1:0] PAUSE_PUMP    = 3'd2;
    localparam logic [PAUSE_W-1:0] PAUSE_REREAD  = 3'd3;
    localparam logic [PAUSE_W-1:0] PAUSE_NONE    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_RUN_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_LIMIT     = 2'd3;

    typedef struct packed {
        logic [PAUSE_W-1:0]       pause_code;
        logic                     pump_on;
        logic                     heater_on;
        logic                     relay_changed;
        logic signed [TEMP_W-1:0] reported_value;
        logic                     publish_now;
    } t_result;

    typedef struct packed {
        logic signed [TEMP_W-1:0] lower_threshold;
        logic signed [TEMP_W-1:0] upper_threshold;
        logic [COUNT_W-1:0]       pump_run_limit;
        logic [COUNT_W-1:0]       quiet_limit;
    } t_cfg;

endpackage

// ----- sv/trc_core.sv -----
// trc_core: reading filter, history, counters and relay mode machine
// depends on trc_pkg; updates its state on every accepted reading
module trc_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic signed [trc_pkg::TEMP_W-1:0] i_reading,
    input  trc_pkg::t_cfg                     i_cfg,
    output trc_pkg::t_result                  o_result
);

    trc_pkg::t_mode                    r_mode, n_mode;
    logic                              r_started, n_started;
    logic signed [trc_pkg::TEMP_W-1:0] r_last, n_last;
    logic signed [trc_pkg::TEMP_W-1:0] r_prev, n_prev;
    logic signed [trc_pkg::TEMP_W-1:0] r_older, n_older;
    logic                              r_reread, n_reread;
    logic [trc_pkg::COUNT_W-1:0]       r_run, n_run;
    logic [trc_pkg::COUNT_W-1:0]       r_quiet, n_quiet;

    logic signed [trc_pkg::TEMP_W-1:0] prev1;
    logic signed [trc_pkg::TEMP_W-1:0] older1;
    logic [trc_pkg::COUNT_W-1:0]       quiet1;
    logic [trc_pkg::COUNT_W-1:0]       run_inc;
    logic signed [trc_pkg::TEMP_W:0]   diff;
    logic                              jump;
    trc_pkg::t_result                  res;

    always_comb begin
        prev1   = (r_last != r_prev) ? r_last : r_prev;
        older1  = (r_last != r_prev) ? r_prev : r_older;
        quiet1  = (r_quiet == trc_pkg::COUNT_MAX) ? r_quiet : r_quiet + 1'b1;
        run_inc = (r_run == trc_pkg::COUNT_MAX) ? r_run : r_run + 1'b1;
        diff    = {i_reading[trc_pkg::TEMP_W-1], i_reading} - {prev1[trc_pkg::TEMP_W-1], prev1};
        jump    = (diff > 14'sd1) || (diff < -14'sd1);

        n_mode    = r_mode;
        n_started = r_started;
        n_last    = r_last;
        n_prev    = r_prev;
        n_older   = r_older;
        n_reread  = r_reread;
        n_run     = r_run;
        n_quiet   = r_quiet;

        res.publish_now    = 1'b0;
        res.reported_value = i_reading;
        res.relay_changed  = 1'b0;
        res.pause_code     = trc_pkg::PAUSE_NONE;

        if (!r_started) begin
            n_started       = 1'b1;
            n_last          = i_reading;
            n_prev          = i_reading;
            res.publish_now = 1'b1;
        end else begin
            n_prev  = prev1;
            n_older = older1;
            n_quiet = quiet1;
            if (jump && !r_reread) begin
                // first sight of a jump: hold the old value and ask for a re-read
                n_reread           = 1'b1;
                n_last             = prev1;
                res.reported_value = prev1;
                res.pause_code     = trc_pkg::PAUSE_REREAD;
            end else begin
                if (jump) begin
                    n_reread = 1'b0;
                end
                res.publish_now = (i_reading != prev1) && (i_reading != older1);
                if (res.publish_now) begin
                    n_quiet = '0;
                end
                n_last = i_reading;
                unique case (r_mode)
                    trc_pkg::MODE_STANDBY: begin
                        n_run    = '0;
                        n_reread = 1'b0;
                        if (i_reading < i_cfg.lower_threshold) begin
                            n_mode            = trc_pkg::MODE_HEATING;
                            res.relay_changed = 1'b1;
                            res.pause_code    = trc_pkg::PAUSE_HEATER;
                        end else if (i_reading > i_cfg.upper_threshold) begin
                            n_mode            = trc_pkg::MODE_COOLING;
                            res.relay_changed = 1'b1;
                            res.pause_code    = trc_pkg::PAUSE_PUMP;
                        end else begin
                            if (n_quiet > i_cfg.quiet_limit) begin
                                res.publish_now = 1'b1;
                                n_quiet         = '0;
                            end
                            res.pause_code = trc_pkg::PAUSE_STANDBY;
                        end
                    end
                    trc_pkg::MODE_COOLING: begin
                        if ((i_reading < i_cfg.upper_threshold) ||
                            (r_run > i_cfg.pump_run_limit)) begin
                            n_mode            = trc_pkg::MODE_STANDBY;
                            res.relay_changed = 1'b1;
                            n_run             = '0;
                            res.pause_code    = trc_pkg::PAUSE_STANDBY;
                        end else begin
                            n_run          = run_inc;
                            res.pause_code = trc_pkg::PAUSE_PUMP;
                        end
                    end
                    trc_pkg::MODE_HEATING: begin
                        if (i_reading > i_cfg.lower_threshold) begin
                            n_mode            = trc_pkg::MODE_STANDBY;
                            res.relay_changed = 1'b1;
                            n_quiet           = '0;
                            res.pause_code    = trc_pkg::PAUSE_STANDBY;
                        end else begin
                            n_run          = run_inc;
                            res.pause_code = trc_pkg::PAUSE_HEATER;
                        end
                    end
                    default: begin
                        n_mode         = trc_pkg::MODE_STANDBY;
                        res.pause_code = trc_pkg::PAUSE_NONE;
                    end
                endcase
            end
        end

        res.heater_on = (n_mode == trc_pkg::MODE_HEATING);
        res.pump_on   = (n_mode == trc_pkg::MODE_COOLING);
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= trc_pkg::MODE_STANDBY;
            r_started <= 1'b0;
            r_last    <= '0;
            r_prev    <= '0;
            r_older   <= '0;
            r_reread  <= 1'b0;
            r_run     <= '0;
            r_quiet   <= '0;
        end else if (i_push) begin
            r_mode    <= n_mode;
            r_started <= n_started;
            r_last    <= n_last;
            r_prev    <= n_prev;
            r_older   <= n_older;
            r_reread  <= n_reread;
            r_run     <= n_run;
            r_quiet   <= n_quiet;
        end
    end

endmodule

// ----- sv/trc_out_buf.sv -----
// trc_out_buf: result register with a skid stage
// depends on trc_pkg; holds up to two results while the receiver stalls
module trc_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  trc_pkg::t_result i_data,
    output logic             o_can_push,
    output logic             o_valid,
    input  logic             i_ready,
    output trc_pkg::t_result o_data
);

    logic             r_main_vld;
    logic             r_skid_vld;
    trc_pkg::t_result r_main;
    trc_pkg::t_result r_skid;
    logic             pop;

    assign pop        = r_main_vld && i_ready;
    assign o_can_push = !r_skid_vld;
    assign o_valid    = r_main_vld;
    assign o_data     = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pop || !r_main_vld) begin
            if (r_skid_vld) begin
                r_main_vld <= 1'b1;
                r_skid_vld <= i_push;
            end else begin
                r_main_vld <= i_push;
            end
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_main_vld) begin
            if (r_skid_vld) begin
                r_main <= r_skid;
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

// ----- sv/thermostat_relay_controller.sv -----
// thermostat_relay_controller: top level, stream ports and config registers
// depends on trc_pkg, trc_core and trc_out_buf
//
// usage:
//   one temperature reading (signed quarter degrees) enters per transfer on
//   the s_axis side; exactly one result leaves per reading on m_axis.
//   the reading is evaluated in the cycle it is accepted and its result
//   is registered into the output register, or into the skid stage when
//   the output register holds a result that the receiver does not take;
//   one reading per cycle is taken while s_axis_tready is high. the skid
//   stage lets a new reading in while one result waits; s_axis_tready
//   drops whenever the skid stage holds a result.
//   config registers are written through i_cfg_wr_en / i_cfg_index /
//   i_cfg_wdata, one per cycle; write them only while the block is idle (not enforced by the block).
//   reset (synchronous, active low) empties the output stages, sets the
//   thresholds and limits to their defaults and clears history, counters
//   and mode (standby, relays off).
module thermostat_relay_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [12:0] reading, [15:13] zero
    input  logic [trc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] publish_now, [13:1] reported_value, [14] relay_changed,
    // [15] heater_on, [16] pump_on, [19:17] pause_code, [23:20] zero
    output logic [trc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [trc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [trc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    trc_pkg::t_cfg    r_cfg;
    trc_pkg::t_result core_result;
    trc_pkg::t_result buf_result;
    logic             can_push;
    logic             push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_threshold <= 13'sd256;
            r_cfg.upper_threshold <= 13'sd272;
            r_cfg.pump_run_limit  <= 16'd30;
            r_cfg.quiet_limit     <= 16'd15;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                trc_pkg::CFG_LOWER_THRESHOLD:
                    r_cfg.lower_threshold <= i_cfg_wdata[trc_pkg::TEMP_W-1:0];
                trc_pkg::CFG_UPPER_THRESHOLD:
                    r_cfg.upper_threshold <= i_cfg_wdata[trc_pkg::TEMP_W-1:0];
                trc_pkg::CFG_PUMP_RUN_LIMIT:
                    r_cfg.pump_run_limit <= i_cfg_wdata;
                trc_pkg::CFG_QUIET_LIMIT:
                    r_cfg.quiet_limit <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = can_push;
    assign push          = s_axis_tvalid && can_push;

    trc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_reading (s_axis_tdata[trc_pkg::TEMP_W-1:0]),
        .i_cfg     (r_cfg),
        .o_result  (core_result)
    );

    trc_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (core_result),
        .o_can_push (can_push),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (buf_result)
    );

    assign m_axis_tdata = {4'd0, buf_result};

endmodule
